FILE: rtl/gsa_pkg.sv
// Shared types for the generational slot allocator: opcodes, states, control structs.
package gsa_pkg;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_CHECK   = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RD_STACK,
    ST_POP,
    ST_RD_GEN,
    ST_EXEC,
    ST_RESP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch the request
    logic pop;       // take the stack top as the working slot
    logic fresh;     // allocate the next fresh slot
    logic fail;      // build a failure / invalid-handle result
    logic exec;      // generation read is back: finish the op
    logic load_out;  // move the result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic stack_empty;
    logic fresh_avail;
    logic in_range;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/gsa_req_if.sv
// Request channel: valid/ready plus opcode and handle.
interface gsa_req_if #(
  parameter int SLOT_W = 10,
  parameter int GEN_W  = 32
);
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [SLOT_W-1:0] handle_slot;
  logic [GEN_W-1:0]  handle_generation;

  modport source (output valid, output op, output handle_slot, output handle_generation,
                  input ready);
  modport sink   (input valid, input op, input handle_slot, input handle_generation,
                  output ready);
endinterface

FILE: rtl/gsa_rsp_if.sv
// Response channel: valid/ready plus slot, generation and status flags.
interface gsa_rsp_if #(
  parameter int SLOT_W = 10,
  parameter int GEN_W  = 32
);
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] out_slot;
  logic [GEN_W-1:0]  out_generation;
  logic              success;
  logic              full_res;

  modport source (output valid, output out_slot, output out_generation, output success,
                  output full_res, input ready);
  modport sink   (input valid, input out_slot, input out_generation, input success,
                  input full_res, output ready);
endinterface

FILE: rtl/gsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/gsa_ctrl.sv
// Sequencer for the allocator: steps each request through its memory reads.
module gsa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  gsa_pkg::sts_t sts,
  output gsa_pkg::cmd_t cmd
);

  gsa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      gsa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = gsa_pkg::ST_DISPATCH;
        end
      end
      gsa_pkg::ST_DISPATCH: begin
        if (sts.op == gsa_pkg::OP_CREATE) begin
          if (!sts.stack_empty) begin
            state_next = gsa_pkg::ST_RD_STACK;
          end else if (sts.fresh_avail) begin
            cmd.fresh  = 1'b1;
            state_next = gsa_pkg::ST_RESP;
          end else begin
            cmd.fail   = 1'b1;
            state_next = gsa_pkg::ST_RESP;
          end
        end else if (sts.in_range) begin
          state_next = gsa_pkg::ST_RD_GEN;
        end else begin
          cmd.fail   = 1'b1;
          state_next = gsa_pkg::ST_RESP;
        end
      end
      gsa_pkg::ST_RD_STACK: state_next = gsa_pkg::ST_POP;
      gsa_pkg::ST_POP: begin
        cmd.pop    = 1'b1;
        state_next = gsa_pkg::ST_RD_GEN;
      end
      gsa_pkg::ST_RD_GEN: state_next = gsa_pkg::ST_EXEC;
      gsa_pkg::ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = gsa_pkg::ST_RESP;
      end
      gsa_pkg::ST_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = gsa_pkg::ST_IDLE;
        end
      end
      default: state_next = gsa_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/gsa_dp.sv
// Allocator datapath: generation table, free stack, counters, result and output registers.
module gsa_dp #(
  parameter int SLOT_COUNT = 1024,
  parameter int GEN_BITS   = 32,
  localparam int SLOT_W = $clog2(SLOT_COUNT),
  localparam int CNT_W  = SLOT_W + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          in_op,
  input  logic [SLOT_W-1:0]   in_slot,
  input  logic [GEN_BITS-1:0] in_gen,
  input  gsa_pkg::cmd_t       cmd,
  output gsa_pkg::sts_t       sts,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [GEN_BITS-1:0] out_gen,
  output logic                out_success,
  output logic                out_full
);

  gsa_pkg::op_t        op_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [GEN_BITS-1:0] hgen_q;
  logic [CNT_W-1:0]    free_count;
  logic [CNT_W-1:0]    fresh_slot;
  logic [CNT_W-1:0]    cnt_dec;

  logic [SLOT_W-1:0]   res_slot;
  logic [GEN_BITS-1:0] res_gen;
  logic                res_ok;
  logic                res_full;

  logic [GEN_BITS-1:0] gen_rdata;
  logic [GEN_BITS-1:0] gen_inc;
  logic [SLOT_W-1:0]   stk_rdata;
  logic                live;
  logic                tbl_we;
  logic [SLOT_W-1:0]   tbl_waddr;
  logic [GEN_BITS-1:0] tbl_wdata;
  logic                stk_we;

  assign cnt_dec = free_count - 1'b1;
  assign gen_inc = gen_rdata + 1'b1;
  assign live    = (gen_rdata == hgen_q) && (free_count < CNT_W'(SLOT_COUNT));

  assign tbl_we    = cmd.fresh ||
                     (cmd.exec && ((op_q == gsa_pkg::OP_CREATE) ||
                                   ((op_q == gsa_pkg::OP_DESTROY) && live)));
  assign tbl_waddr = cmd.fresh ? fresh_slot[SLOT_W-1:0] : slot_q;
  assign tbl_wdata = cmd.fresh ? GEN_BITS'(1) : gen_inc;
  assign stk_we    = cmd.exec && (op_q == gsa_pkg::OP_DESTROY) && live;

  gsa_ram #(.WIDTH(GEN_BITS), .DEPTH(SLOT_COUNT)) u_gen_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (slot_q),
    .rdata (gen_rdata)
  );

  gsa_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_free_stk (
    .clk   (clk),
    .we    (stk_we),
    .waddr (free_count[SLOT_W-1:0]),
    .wdata (slot_q),
    .raddr (cnt_dec[SLOT_W-1:0]),
    .rdata (stk_rdata)
  );

  assign sts.op          = op_q;
  assign sts.stack_empty = (free_count == '0);
  assign sts.fresh_avail = (fresh_slot < CNT_W'(SLOT_COUNT));
  assign sts.in_range    = (slot_q != '0) && ({1'b0, slot_q} < fresh_slot);
  assign sts.out_free    = !out_valid || out_ready;

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= '0;
      fresh_slot <= CNT_W'(1);
    end else begin
      if (cmd.pop) begin
        free_count <= cnt_dec;
      end else if (stk_we) begin
        free_count <= free_count + 1'b1;
      end
      if (cmd.fresh) begin
        fresh_slot <= fresh_slot + 1'b1;
      end
    end
  end

  // request and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= gsa_pkg::op_t'(in_op);
      slot_q <= in_slot;
      hgen_q <= in_gen;
    end else if (cmd.pop) begin
      slot_q <= stk_rdata;
    end

    if (cmd.fresh) begin
      res_slot <= fresh_slot[SLOT_W-1:0];
      res_gen  <= GEN_BITS'(1);
      res_ok   <= 1'b1;
      res_full <= 1'b0;
    end else if (cmd.fail) begin
      res_slot <= (op_q == gsa_pkg::OP_CREATE) ? '0 : slot_q;
      res_gen  <= '0;
      res_ok   <= 1'b0;
      res_full <= (op_q == gsa_pkg::OP_CREATE);
    end else if (cmd.exec) begin
      res_slot <= slot_q;
      res_full <= 1'b0;
      case (op_q)
        gsa_pkg::OP_CREATE: begin
          res_gen <= gen_inc;
          res_ok  <= 1'b1;
        end
        gsa_pkg::OP_QUERY: begin
          res_gen <= gen_rdata;
          res_ok  <= 1'b1;
        end
        default: begin
          res_gen <= '0;
          res_ok  <= live;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_slot    <= res_slot;
      out_gen     <= res_gen;
      out_success <= res_ok;
      out_full    <= res_full;
    end
  end

  // every freed slot was once handed out fresh
  a_free_below_fresh: assert property (@(posedge clk) disable iff (rst)
    free_count < fresh_slot)
    else $error("free count not below fresh slot counter");

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    (fresh_slot != '0) && (fresh_slot <= CNT_W'(SLOT_COUNT)))
    else $error("fresh slot counter out of range");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> (free_count == CNT_W'($past(free_count) - 1'b1)))
    else $error("pop did not shrink the free stack by one");

  a_no_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(stk_we && cmd.pop))
    else $error("push and pop in the same cycle");

endmodule

FILE: rtl/generational_slot_allocator.sv
// Top level of the generational slot allocator: sequencer plus datapath.
//
// Handles are {slot, generation}. Slot 0 is reserved and never valid.
// req channel (sink): op = create / destroy / check / query, with handle fields.
// rsp channel (source): one transfer per request carrying out_slot,
//   out_generation, success and full_res.
// Create pops the most recently freed slot, else takes the next fresh slot,
// and bumps that slot's generation (a fresh slot comes out at generation 1).
// Destroy of a live handle bumps the generation and pushes the slot.
//
// One request is in flight at a time. A fresh create, a failed create or an
// out-of-range handle goes straight to the result; destroy / check / query of
// an allocated slot first reads the registered-read generation table, and a
// create from the free stack reads the free stack and then that table, each
// walked in turn by the sequencer. A new request is taken in the cycle after
// the previous result is loaded, never while one is still in progress.
// The result sits in an output register, so the next request is accepted while
// rsp is stalled; that request waits for the register to drain before loading.
// Reset (rst, synchronous) empties the free stack and sets the fresh slot to 1;
// the memories are not cleared: only entries already written are ever read.
module generational_slot_allocator #(
  parameter int SLOT_COUNT = 1024,
  parameter int GEN_BITS   = 32
) (
  input logic      clk,
  input logic      rst,
  gsa_req_if.sink  req,
  gsa_rsp_if.source rsp
);

  gsa_pkg::cmd_t cmd;
  gsa_pkg::sts_t sts;

  gsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gsa_dp #(.SLOT_COUNT(SLOT_COUNT), .GEN_BITS(GEN_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_op       (req.op),
    .in_slot     (req.handle_slot),
    .in_gen      (req.handle_generation),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .out_slot    (rsp.out_slot),
    .out_gen     (rsp.out_generation),
    .out_success (rsp.success),
    .out_full    (rsp.full_res)
  );

endmodule
